### design/mtdm_pkg.sv
// shared types and constants for the mecanum and tank drive mixer
`default_nettype none

package mtdm_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int PROD_W    = 2 * IN_W;
    localparam int SQ_W      = PROD_W - FRAC_BITS + 1;
    localparam int CW_W      = IN_W;
    localparam int WHEEL_W   = imax(SQ_W, CW_W) + 2;
    localparam int MAG_W     = WHEEL_W;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int CMP_W     = imax(MAG_W, FRAC_BITS + 1) + 1;
    localparam int CALC_W    = imax(WHEEL_W, Q_W + 1) + 1;
    localparam int LANES     = 4;
    localparam int FRONT_STG = 5;
    localparam int N_STG     = FRONT_STG + Q_W + 1;

    localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << FRAC_BITS;

    localparam int MODE_W     = 2;
    localparam int MASK_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [MODE_W-1:0] MODE_MECANUM     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TANK        = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BACK_EXTEND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK = 1'd1;

    localparam int LANE_FL    = 0;
    localparam int LANE_RL    = 1;
    localparam int LANE_FR    = 2;
    localparam int LANE_RR    = 3;
    localparam int MASK_LEFT  = 4;
    localparam int MASK_RIGHT = 5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MASK_W-1:0] mask;
    } t_cfg;

    typedef struct packed {
        logic                      neg;
        logic signed [WHEEL_W-1:0] wheel;
        logic [MAG_W-1:0]          rem;
        logic                      nxt;
        logic [Q_W-1:0]            quo;
    } t_lane;

    typedef struct packed {
        logic                    norm;
        logic [MAG_W-1:0]        mx;
        t_lane [LANES-1:0]       lane;
    } t_div;

endpackage

`default_nettype wire

### design/mtdm_front.sv
// front stages: magnitudes, signed squares, wheel mixing and largest magnitude
`default_nettype none

module mtdm_front
    import mtdm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic [FRONT_STG-1:0]   i_en,
    input  wire t_cfg                   i_cfg,
    input  wire logic signed [IN_W-1:0] i_strafe_x,
    input  wire logic signed [IN_W-1:0] i_left_y,
    input  wire logic signed [IN_W-1:0] i_turn_x,
    input  wire logic signed [IN_W-1:0] i_right_y,
    output t_div                        o_div
);

    function automatic logic [IN_W-1:0] in_mag(input logic signed [IN_W-1:0] v);
        return v[IN_W-1] ? IN_W'(~v + IN_W'(1)) : IN_W'(v);
    endfunction

    function automatic logic signed [SQ_W-1:0] sq_signed(input logic [IN_W-1:0] a,
                                                         input logic neg);
        logic [PROD_W-1:0]       prod;
        logic signed [SQ_W-1:0]  s;
        prod = PROD_W'(a) * PROD_W'(a);
        s    = $signed({1'b0, prod[PROD_W-1:FRAC_BITS]});
        return neg ? -s : s;
    endfunction

    logic mecanum;

    // stage a
    logic [IN_W-1:0]          r_a_sx_mag, r_a_ly_mag, r_a_ry_mag;
    logic                     r_a_sx_neg, r_a_ly_neg, r_a_ry_neg;
    logic signed [CW_W-1:0]   r_a_cw;
    logic signed [IN_W+1:0]   tx_e, ncw, cw_full;

    // stage b
    logic signed [SQ_W-1:0]   r_b_right, r_b_fwd, r_b_rv;
    logic signed [CW_W-1:0]   r_b_cw;

    // stage c
    logic signed [WHEEL_W-1:0] r_c_wheel [LANES];
    logic signed [WHEEL_W-1:0] n_c_wheel [LANES];
    logic signed [WHEEL_W-1:0] fwd_e, right_e, cw_e, rv_e;

    // stage d
    logic signed [WHEEL_W-1:0] r_d_wheel [LANES];
    logic [MAG_W-1:0]          r_d_mag [LANES];
    logic [MAG_W-1:0]          n_d_mag [LANES];
    logic [MAG_W-1:0]          r_d_m01, r_d_m23;

    // stage e
    t_div                      r_e;
    t_div                      n_e;
    logic [MAG_W-1:0]          mx;

    assign mecanum = (i_cfg.mode == MODE_MECANUM);

    // -0.75 scaling, truncated toward zero
    always_comb begin
        tx_e    = (IN_W+2)'(i_turn_x);
        ncw     = -(tx_e + (tx_e <<< 1));
        cw_full = ncw[IN_W+1] ? ((ncw + (IN_W+2)'(3)) >>> 2) : (ncw >>> 2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a_sx_mag <= in_mag(i_strafe_x);
            r_a_ly_mag <= in_mag(i_left_y);
            r_a_ry_mag <= in_mag(i_right_y);
            r_a_sx_neg <= i_strafe_x[IN_W-1];
            r_a_ly_neg <= i_left_y[IN_W-1];
            r_a_ry_neg <= i_right_y[IN_W-1];
            r_a_cw     <= CW_W'(cw_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b_right <= sq_signed(r_a_sx_mag, r_a_sx_neg);
            r_b_fwd   <= sq_signed(r_a_ly_mag, r_a_ly_neg);
            r_b_rv    <= sq_signed(r_a_ry_mag, r_a_ry_neg);
            r_b_cw    <= r_a_cw;
        end
    end

    always_comb begin
        fwd_e   = WHEEL_W'(r_b_fwd);
        right_e = WHEEL_W'(r_b_right);
        cw_e    = WHEEL_W'(r_b_cw);
        rv_e    = WHEEL_W'(r_b_rv);
        if (mecanum) begin
            n_c_wheel[LANE_FL] = fwd_e + cw_e + right_e;
            n_c_wheel[LANE_RL] = fwd_e + cw_e - right_e;
            n_c_wheel[LANE_FR] = fwd_e - cw_e - right_e;
            n_c_wheel[LANE_RR] = fwd_e - cw_e + right_e;
        end else begin
            n_c_wheel[LANE_FL] = fwd_e;
            n_c_wheel[LANE_RL] = fwd_e;
            n_c_wheel[LANE_FR] = rv_e;
            n_c_wheel[LANE_RR] = rv_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_c_wheel <= n_c_wheel;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_d_mag[l] = r_c_wheel[l][WHEEL_W-1] ? MAG_W'(-r_c_wheel[l])
                                                 : MAG_W'(r_c_wheel[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_d_wheel <= r_c_wheel;
            r_d_mag   <= n_d_mag;
            r_d_m01   <= (n_d_mag[0] > n_d_mag[1]) ? n_d_mag[0] : n_d_mag[1];
            r_d_m23   <= (n_d_mag[2] > n_d_mag[3]) ? n_d_mag[2] : n_d_mag[3];
        end
    end

    // divider set-up: remainder starts at mag/2, the low bit shifts in first
    always_comb begin
        mx        = (r_d_m01 > r_d_m23) ? r_d_m01 : r_d_m23;
        n_e.mx    = mx;
        n_e.norm  = mecanum && (CMP_W'(mx) > ONE_CMP);
        for (int l = 0; l < LANES; l++) begin
            n_e.lane[l].neg   = r_d_wheel[l][WHEEL_W-1];
            n_e.lane[l].wheel = r_d_wheel[l];
            n_e.lane[l].rem   = r_d_mag[l] >> 1;
            n_e.lane[l].nxt   = r_d_mag[l][0];
            n_e.lane[l].quo   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_e <= n_e;
        end
    end

    assign o_div = r_e;

endmodule

`default_nettype wire

### design/mtdm_div_stage.sv
// one restoring divide step for all four wheels
`default_nettype none

module mtdm_div_stage
    import mtdm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_div i_div,
    output t_div      o_div
);

    t_div             r_div;
    t_div             n_div;
    logic [MAG_W:0]   trial [LANES];
    logic             ge [LANES];

    always_comb begin
        n_div = i_div;
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {i_div.lane[l].rem, i_div.lane[l].nxt};
            ge[l]    = (trial[l] >= {1'b0, i_div.mx});
            n_div.lane[l].rem = ge[l] ? MAG_W'(trial[l] - {1'b0, i_div.mx})
                                      : trial[l][MAG_W-1:0];
            n_div.lane[l].quo = {i_div.lane[l].quo[Q_W-2:0], ge[l]};
            n_div.lane[l].nxt = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

### design/mtdm_out.sv
// output stage: quotient or raw wheel, inversion and saturation
`default_nettype none

module mtdm_out
    import mtdm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire t_cfg                    i_cfg,
    input  wire t_div                    i_div,
    output logic [LANES-1:0][OUT_W-1:0]  o_drive
);

    localparam logic signed [CALC_W-1:0] SAT_HI = CALC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [CALC_W-1:0] SAT_LO = -CALC_W'(1 << (OUT_W - 1));

    logic [LANES-1:0][OUT_W-1:0]  r_drive;
    logic [LANES-1:0][OUT_W-1:0]  n_drive;
    logic signed [CALC_W-1:0]     q_s [LANES];
    logic signed [CALC_W-1:0]     val [LANES];
    logic signed [CALC_W-1:0]     fin [LANES];
    logic                         inv [LANES];
    logic                         mecanum;

    assign mecanum = (i_cfg.mode == MODE_MECANUM);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            q_s[l] = CALC_W'($signed({1'b0, i_div.lane[l].quo}));
            if (i_div.norm) begin
                val[l] = i_div.lane[l].neg ? -q_s[l] : q_s[l];
            end else begin
                val[l] = CALC_W'(i_div.lane[l].wheel);
            end
            if (mecanum) begin
                inv[l] = i_cfg.mask[l];
            end else begin
                inv[l] = (l < 2) ? i_cfg.mask[MASK_LEFT] : i_cfg.mask[MASK_RIGHT];
            end
            fin[l] = inv[l] ? -val[l] : val[l];
            if (fin[l] > SAT_HI) begin
                n_drive[l] = SAT_HI[OUT_W-1:0];
            end else if (fin[l] < SAT_LO) begin
                n_drive[l] = SAT_LO[OUT_W-1:0];
            end else begin
                n_drive[l] = fin[l][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

`default_nettype wire

### design/mecanum_tank_drive_mixer.sv
// top level of the mecanum and tank drive mixer
`default_nettype none

// Takes one set of four Q2.14 joystick axes per cycle while o_stall is low and returns one
// set of four wheel commands through the pipeline: 5 front stages for magnitude, square,
// mix and largest magnitude, then 15 stages of the normalizing divider, one quotient bit
// per stage for all four wheels, then the output register. Stages fill bubbles, so items
// keep entering while the output waits, until every stage is full.
// The drive mode and inversion mask are read live, so write them only while idle.

module mecanum_tank_drive_mixer
    import mtdm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [IN_W-1:0]  i_strafe_x,
    input  wire logic signed [IN_W-1:0]  i_left_y,
    input  wire logic signed [IN_W-1:0]  i_turn_x,
    input  wire logic signed [IN_W-1:0]  i_right_y,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [OUT_W-1:0]      o_fl_drive,
    output logic signed [OUT_W-1:0]      o_rl_drive,
    output logic signed [OUT_W-1:0]      o_fr_drive,
    output logic signed [OUT_W-1:0]      o_rr_drive,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg                         r_cfg;
    logic [N_STG-1:0]             r_vld;
    logic [N_STG-1:0]             n_vld;
    logic [N_STG-1:0]             w_ready;
    logic                         w_in_acc;
    logic                         w_out_acc;
    t_div                         w_div [Q_W+1];
    logic [LANES-1:0][OUT_W-1:0]  w_drive;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_TANK;
            r_cfg.mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_DRIVE_MODE: begin
                    r_cfg.mode <= i_cfg_data[MODE_W-1:0];
                end
                REG_INVERT_MASK: begin
                    r_cfg.mask <= i_cfg_data[MASK_W-1:0];
                end
            endcase
        end
    end

    // a stage may load when some stage at or after it is empty or the output drains
    always_comb begin
        for (int k = 0; k < N_STG; k++) begin
            w_ready[k] = !i_stall
                || ((r_vld | ((N_STG'(1) << k) - N_STG'(1))) != {N_STG{1'b1}});
        end
    end

    assign n_vld     = (w_ready & {r_vld[N_STG-2:0], i_valid}) | (~w_ready & r_vld);
    assign o_stall   = !w_ready[0];
    assign o_valid   = r_vld[N_STG-1];
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    mtdm_front u_front (
        .i_clk      (i_clk),
        .i_en       (w_ready[FRONT_STG-1:0]),
        .i_cfg      (r_cfg),
        .i_strafe_x (i_strafe_x),
        .i_left_y   (i_left_y),
        .i_turn_x   (i_turn_x),
        .i_right_y  (i_right_y),
        .o_div      (w_div[0])
    );

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        mtdm_div_stage u_div_stage (
            .i_clk (i_clk),
            .i_en  (w_ready[FRONT_STG+k]),
            .i_div (w_div[k]),
            .o_div (w_div[k+1])
        );
    end

    mtdm_out u_out (
        .i_clk   (i_clk),
        .i_en    (w_ready[N_STG-1]),
        .i_cfg   (r_cfg),
        .i_div   (w_div[Q_W]),
        .o_drive (w_drive)
    );

    assign o_fl_drive = w_drive[LANE_FL];
    assign o_rl_drive = w_drive[LANE_RL];
    assign o_fr_drive = w_drive[LANE_FR];
    assign o_rr_drive = w_drive[LANE_RR];

`ifndef SYNTHESIS
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output register is empty");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && i_stall) |-> o_stall)
        else $error("transfer accepted into a full stalled pipeline");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(r_vld) == $past($countones(r_vld))
                + $past(w_in_acc) - $past(w_out_acc)))
        else $error("pipeline lost or duplicated an item");
`endif

endmodule

`default_nettype wire
